// ----- rtl/core/cmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmc_pkg: shared types and codes of the coverage and mutation counter
// Request and result payloads, the front-to-back queue entry, CIGAR op codes
// and register map.
// ----------------------------------------------------------------------------
package cmc_pkg;

   // Span bounds cover every supported reference depth, up to and including it
   localparam int SPAN_W      = 21;
   localparam int QUEUE_DEPTH = 2;
   localparam int REF_LEN_W   = 13;

   localparam logic [REF_LEN_W-1:0] REF_LENGTH_RESET = 13'd4096;

   // Register byte addresses
   localparam logic [1:0] CSR_REF_LENGTH = 2'd0;

   // Request opcodes
   localparam logic OPC_ELEMENT = 1'b0;
   localparam logic OPC_READOUT = 1'b1;

   // CIGAR operations that do something
   localparam logic [3:0] OP_M  = 4'd0;
   localparam logic [3:0] OP_I  = 4'd1;
   localparam logic [3:0] OP_D  = 4'd2;
   localparam logic [3:0] OP_N  = 4'd3;
   localparam logic [3:0] OP_EQ = 4'd7;
   localparam logic [3:0] OP_X  = 4'd8;

   typedef struct packed {
      logic        opcode;
      logic        first_of_read;
      logic [30:0] read_start;
      logic [3:0]  cigar_op;
      logic [27:0] op_length;
      logic        last_of_read;
      logic [11:0] query_index;
   } req_type;

   typedef struct packed {
      logic [31:0] coverage_count;
      logic [31:0] mutation_count;
      logic [31:0] read_count;
      logic [31:0] next_position;
   } rsp_type;

   typedef struct packed {
      logic              readout;
      logic              query_ok;
      logic [11:0]       query_index;
      logic              upd_cov;
      logic              upd_mut;
      logic [SPAN_W-1:0] span_lo;
      logic [SPAN_W-1:0] span_hi;
      logic [31:0]       read_count;
      logic [31:0]       next_position;
   } entry_type;

endpackage
`default_nettype wire

// ----- rtl/core/cmc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmc_queue: short queue between front and back
// Holds classified work so that the front and the memory sweep stall apart.
// ----------------------------------------------------------------------------
module cmc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire cmc_pkg::entry_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output cmc_pkg::entry_type      head,
   output logic                    empty
);
   import cmc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;

   assign full  = (fill_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/cmc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmc_front: request intake and classification
// Tracks the reference position and read count, decodes the CIGAR op and
// turns it into a clipped span of memory updates for the back end.
// ----------------------------------------------------------------------------
module cmc_front #(
   parameter int REF_DEPTH,
   parameter int COUNT_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire cmc_pkg::req_type              req_data,
   input  wire logic [cmc_pkg::REF_LEN_W-1:0] ref_length,
   input  wire logic                          hold_off,
   input  wire logic                          queue_full,
   output logic                               push,
   output cmc_pkg::entry_type                 push_data
);
   import cmc_pkg::*;

   req_type                item_ff, item_in;
   logic                   held_ff, held_in;
   logic [31:0]            pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0] reads_ff, reads_in;

   logic                   accept;
   logic                   readout;
   logic                   upd_cov, upd_mut, advances, nonempty;
   logic [27:0]            eff_len;
   logic [31:0]            base;
   logic [32:0]            sum, lim_x, hi_x;
   logic [SPAN_W-1:0]      limit;
   logic [31:0]            next_pos;
   logic [63:0]            reads_x;

   assign busy    = hold_off || held_ff;
   assign accept  = start && !busy;
   assign push    = held_ff && !queue_full;
   assign readout = (item_ff.opcode == OPC_READOUT);

   always_comb begin
      upd_cov  = 1'b0;
      upd_mut  = 1'b0;
      advances = 1'b0;
      eff_len  = item_ff.op_length;
      unique case (item_ff.cigar_op) inside
         OP_M, OP_EQ: begin
            upd_cov  = 1'b1;
            advances = 1'b1;
         end
         OP_X: begin
            upd_cov  = 1'b1;
            upd_mut  = 1'b1;
            advances = 1'b1;
         end
         OP_D: begin
            upd_mut  = 1'b1;
            advances = 1'b1;
         end
         OP_I: begin
            // one mutation at the current position, whatever the length
            upd_mut = 1'b1;
            eff_len = 28'd1;
         end
         OP_N: begin
            advances = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (SPAN_W'(ref_length) < SPAN_W'(REF_DEPTH)) begin
         limit = SPAN_W'(ref_length);
      end else begin
         limit = SPAN_W'(REF_DEPTH);
      end
      base     = item_ff.first_of_read ? {1'b0, item_ff.read_start} : pos_ff;
      sum      = {1'b0, base} + {5'b0, eff_len};
      lim_x    = 33'(limit);
      hi_x     = (sum > lim_x) ? lim_x : sum;
      nonempty = ({1'b0, base} < hi_x);
      if (advances) begin
         next_pos = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end else begin
         next_pos = base;
      end

      reads_in = reads_ff;
      pos_in   = pos_ff;
      if (push && !readout) begin
         pos_in = next_pos;
         if (item_ff.last_of_read && (reads_ff != '1)) begin
            reads_in = reads_ff + COUNT_WIDTH'(1);
         end
      end
      reads_x = 64'(reads_in);

      push_data.readout       = readout;
      push_data.query_ok      = (32'(item_ff.query_index) < 32'(REF_DEPTH));
      push_data.query_index   = item_ff.query_index;
      push_data.upd_cov       = !readout && nonempty && upd_cov;
      push_data.upd_mut       = !readout && nonempty && upd_mut;
      push_data.span_lo       = base[SPAN_W-1:0];
      push_data.span_hi       = hi_x[SPAN_W-1:0];
      push_data.read_count    = (reads_x > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                    : reads_x[31:0];
      push_data.next_position = pos_in;
   end

   always_comb begin
      held_in = held_ff;
      item_in = item_ff;
      if (accept) begin
         held_in = 1'b1;
         item_in = req_data;
      end else if (push) begin
         held_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         pos_ff   <= '0;
         reads_ff <= '0;
      end else begin
         held_ff  <= held_in;
         pos_ff   <= pos_in;
         reads_ff <= reads_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule
`default_nettype wire

// ----- rtl/core/cmc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmc_back: count memories and span sweep
// Clears both stores after reset, then runs read-modify-write over each span
// one position per cycle and serves readouts; issues one result per entry.
// ----------------------------------------------------------------------------
module cmc_back #(
   parameter int REF_DEPTH,
   parameter int COUNT_WIDTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   output logic                    clearing,
   input  wire cmc_pkg::entry_type head,
   input  wire logic               empty,
   output logic                    pop,
   output logic                    rsp_valid,
   output cmc_pkg::rsp_type        rsp_data
);
   import cmc_pkg::*;

   localparam int ADDR_W = $clog2(REF_DEPTH);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SPAN  = 4'b0100,
      ST_QUERY = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [ADDR_W:0]        ptr_ff, ptr_in;
   logic [ADDR_W-1:0]      wa_ff, wa_in;
   logic                   pend_ff, pend_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [COUNT_WIDTH-1:0] cov_mem [REF_DEPTH];
   logic [COUNT_WIDTH-1:0] mut_mem [REF_DEPTH];
   logic [COUNT_WIDTH-1:0] cov_rd_ff, mut_rd_ff;
   logic [COUNT_WIDTH-1:0] cov_wd, mut_wd;
   logic [ADDR_W-1:0]      rd_addr, wr_addr;
   logic                   cov_we, mut_we;

   logic                   issue, emit, use_rd;
   logic [63:0]            cov_x, mut_x;

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign issue = (ptr_ff != (ADDR_W + 1)'(head.span_hi));

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      ptr_in   = ptr_ff;
      wa_in    = wa_ff;
      pend_in  = 1'b0;
      pop      = 1'b0;
      emit     = 1'b0;
      use_rd   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(REF_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               if (head.readout) begin
                  state_in = ST_QUERY;
               end else if (head.upd_cov || head.upd_mut) begin
                  ptr_in   = (ADDR_W + 1)'(head.span_lo);
                  state_in = ST_SPAN;
               end else begin
                  emit = 1'b1;
                  pop  = 1'b1;
               end
            end
         end
         ST_SPAN: begin
            if (issue) begin
               ptr_in  = ptr_ff + 1'b1;
               wa_in   = ptr_ff[ADDR_W-1:0];
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               // last write has landed: report and release the entry
               emit     = 1'b1;
               pop      = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            emit     = 1'b1;
            pop      = 1'b1;
            use_rd   = head.query_ok;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory port control: read runs ahead of the write by one position
   always_comb begin
      rd_addr = (state_ff == ST_IDLE) ? ADDR_W'(head.query_index) : ptr_ff[ADDR_W-1:0];
      wr_addr = clearing ? clr_ff : wa_ff;
      cov_we  = clearing || (pend_ff && head.upd_cov);
      mut_we  = clearing || (pend_ff && head.upd_mut);
      if (clearing) begin
         cov_wd = '0;
         mut_wd = '0;
      end else begin
         cov_wd = (cov_rd_ff == '1) ? cov_rd_ff : cov_rd_ff + COUNT_WIDTH'(1);
         mut_wd = (mut_rd_ff == '1) ? mut_rd_ff : mut_rd_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cov_we) begin
         cov_mem[wr_addr] <= cov_wd;
      end
      if (mut_we) begin
         mut_mem[wr_addr] <= mut_wd;
      end
      cov_rd_ff <= cov_mem[rd_addr];
      mut_rd_ff <= mut_mem[rd_addr];
   end

   always_comb begin
      cov_x       = 64'(cov_rd_ff);
      mut_x       = 64'(mut_rd_ff);
      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_data_in.coverage_count = '0;
         rsp_data_in.mutation_count = '0;
         if (use_rd) begin
            rsp_data_in.coverage_count = (cov_x > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                          : cov_x[31:0];
            rsp_data_in.mutation_count = (mut_x > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                          : mut_x[31:0];
         end
         rsp_data_in.read_count    = head.read_count;
         rsp_data_in.next_position = head.next_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      wa_ff       <= wa_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ----- rtl/core/cigar_coverage_mutation_counter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cigar_coverage_mutation_counter_unit: CIGAR coverage and mutation pileup
// Per-position saturating coverage and mutation counts built from CIGAR
// elements, with a read counter, a readout command and a ref_length register.
// ----------------------------------------------------------------------------
// Flow: the front registers an accepted item and pushes its clipped span into the queue;
//   the back end sweeps an element's span and reports once its last write has landed,
//   reads the stores for a readout and reports other items straight away; results are registered.
//   The back end runs read-modify-write one position per cycle; the front holds one item
//   and takes a new one only after pushing the last into the two-entry queue, when it has room.
// Reset: synchronous, then a clearing pass over all REF_DEPTH positions with busy high; no stall.
module cigar_coverage_mutation_counter_unit #(
   parameter int REF_DEPTH   = 4096,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             start,
   output logic                  busy,
   input  wire cmc_pkg::req_type req_data,

   output logic                  rsp_valid,
   output cmc_pkg::rsp_type      rsp_data,

   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [1:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import cmc_pkg::*;

   logic [REF_LEN_W-1:0] ref_length_ff, ref_length_in;
   logic                 csr_write;
   logic                 clearing;
   logic                 queue_full, queue_empty;
   logic                 push, pop;
   entry_type            push_data, head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CSR_REF_LENGTH) ? 32'(ref_length_ff) : '0;

   always_comb begin
      ref_length_in = ref_length_ff;
      if (csr_write && (csr_paddr == CSR_REF_LENGTH)) begin
         ref_length_in = csr_pwdata[REF_LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_length_ff <= REF_LENGTH_RESET;
      end else begin
         ref_length_ff <= ref_length_in;
      end
   end

   cmc_front #(
      .REF_DEPTH   (REF_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .ref_length (ref_length_ff),
      .hold_off   (clearing),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   cmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   cmc_back #(
      .REF_DEPTH   (REF_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .head      (head),
      .empty     (queue_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- verif/tb_cigar_coverage_mutation_counter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cigar_coverage_mutation_counter_unit: self-checking bench for the pileup
// Drives CIGAR elements and readouts through the start/busy command port and
// checks every result strobe against an in-bench pileup of coverage, mutation
// and read counts. A directed table comes first, then random well-formed reads
// with interleaved readouts and noise, under several ref_length settings.
// ----------------------------------------------------------------------------
module tb_cigar_coverage_mutation_counter_unit;
   import cmc_pkg::*;

   localparam int REF_DEPTH     = 4096;
   localparam int COUNT_WIDTH   = 32;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 187;
   localparam int PRINT_LIMIT   = 200;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam longint unsigned POS_MAX = 64'hFFFF_FFFF;

   // CIGAR codes that the block ignores
   localparam logic [3:0] OP_S            = 4'd4;
   localparam logic [3:0] OP_H            = 4'd5;
   localparam logic [3:0] OP_P            = 4'd6;
   localparam logic [3:0] OP_FIRST_UNUSED = 4'd9;
   localparam logic [3:0] OP_TOP          = 4'd15;

   localparam logic [30:0] START_MAX = 31'h7FFF_FFFF;
   localparam logic [27:0] LEN_MAX   = 28'hFFF_FFFF;

   typedef struct {
      req_type item;
      int      reps;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // pileup kept by the bench
   bit [31:0]       coverage_model [REF_DEPTH];
   bit [31:0]       mutation_model [REF_DEPTH];
   bit [31:0]       reads_model;
   longint unsigned position_model;
   logic [12:0]     ref_length_model = REF_LENGTH_RESET;

   rsp_type     expected_counts [$];
   dir_row_type directed [$];
   int          mismatch_count;
   int          items_sent;
   int          gap_ceiling;
   logic [12:0] ref_settings [6] = '{13'd8191, 13'd0, 13'd1, 13'd1500, 13'd4096, 13'd0};

   cigar_coverage_mutation_counter_unit #(
      .REF_DEPTH   (REF_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      // keep the log short on a badly broken build
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   function automatic rsp_type pileup_predict(input req_type r);
      rsp_type         res;
      longint unsigned lim, endp, span, p;
      bit              add_cov, add_mut, moves;
      res = '0;
      if (r.opcode == OPC_READOUT) begin
         res.coverage_count = coverage_model[r.query_index];
         res.mutation_count = mutation_model[r.query_index];
      end else begin
         if (r.first_of_read) position_model = r.read_start;
         add_cov = 1'b0;
         add_mut = 1'b0;
         moves   = 1'b0;
         span    = r.op_length;
         case (r.cigar_op)
            OP_M, OP_EQ: begin
               add_cov = 1'b1;
               moves   = 1'b1;
            end
            OP_X: begin
               add_cov = 1'b1;
               add_mut = 1'b1;
               moves   = 1'b1;
            end
            OP_D: begin
               add_mut = 1'b1;
               moves   = 1'b1;
            end
            OP_I: begin
               // one mutation whatever the length
               add_mut = 1'b1;
               span    = 1;
            end
            OP_N: moves = 1'b1;
            default: ;
         endcase
         lim  = (ref_length_model < REF_DEPTH) ? ref_length_model : REF_DEPTH;
         endp = position_model + span;
         if (endp > lim) endp = lim;
         if (add_cov || add_mut) begin
            for (p = position_model; p < endp; p++) begin
               if (add_cov && coverage_model[p] != COUNT_MAX) coverage_model[p]++;
               if (add_mut && mutation_model[p] != COUNT_MAX) mutation_model[p]++;
            end
         end
         if (moves) begin
            endp = position_model + r.op_length;
            position_model = (endp > POS_MAX) ? POS_MAX : endp;
         end
         if (r.last_of_read && reads_model != COUNT_MAX) reads_model++;
      end
      res.read_count    = reads_model;
      res.next_position = position_model[31:0];
      return res;
   endfunction

   function automatic req_type make_element(input logic first, input logic [30:0] rstart,
                                            input logic [3:0] op, input logic [27:0] len,
                                            input logic last);
      req_type r;
      r               = '0;
      r.opcode        = OPC_ELEMENT;
      r.first_of_read = first;
      r.read_start    = rstart;
      r.cigar_op      = op;
      r.op_length     = len;
      r.last_of_read  = last;
      return r;
   endfunction

   function automatic req_type make_readout(input logic [11:0] index);
      req_type r;
      r             = '0;
      r.opcode      = OPC_READOUT;
      r.query_index = index;
      return r;
   endfunction

   function automatic rsp_type counts_of(input logic [31:0] cov, input logic [31:0] mut,
                                         input logic [31:0] reads, input logic [31:0] pos);
      rsp_type s;
      s.coverage_count = cov;
      s.mutation_count = mut;
      s.read_count     = reads;
      s.next_position  = pos;
      return s;
   endfunction

   function automatic req_type random_req();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic logic [3:0] pick_cigar_op();
      logic [3:0] ops [9] = '{OP_M, OP_I, OP_D, OP_N, OP_S, OP_H, OP_P, OP_EQ, OP_X};
      if ($urandom_range(0, 19) == 0) return 4'($urandom_range(OP_FIRST_UNUSED, OP_TOP));
      if ($urandom_range(0, 2) == 0) return OP_M;
      return ops[$urandom_range(0, 8)];
   endfunction

   function automatic logic [27:0] pick_length();
      case ($urandom_range(0, 39))
         0:       return 28'($urandom);
         1, 2:    return '0;
         default: return 28'($urandom_range(1, 120));
      endcase
   endfunction

   function automatic logic [30:0] pick_start();
      if ($urandom_range(0, 15) == 0) return 31'($urandom);
      return 31'($urandom_range(0, 4300));
   endfunction

   // Present one item, hold it until the block takes it, then log its result.
   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = (gap_ceiling == 0) ? 0 : $urandom_range(0, gap_ceiling);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = pileup_predict(item);
      expected_counts.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Hold off until every result is back and the block has settled.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (expected_counts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write ref_length with junk in the unused bits, then read it back.
   task automatic set_ref_length(input logic [12:0] value);
      logic [31:0] word;
      word        = $urandom;
      word[12:0]  = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_REF_LENGTH;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      ref_length_model = value;
      // go straight to the setup of the read-back transfer
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[12:0] !== value) report_mismatch("ref_length read-back", csr_prdata,
                                                      {19'd0, value});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One read: first element loads the position, last one counts the read.
   task automatic send_random_read();
      int          n_ops;
      req_type     r;
      logic [30:0] rstart;
      rstart = pick_start();
      n_ops  = $urandom_range(1, 6);
      for (int k = 0; k < n_ops; k++) begin
         r               = random_req();
         r.opcode        = OPC_ELEMENT;
         r.first_of_read = (k == 0);
         r.last_of_read  = (k == n_ops - 1);
         r.cigar_op      = pick_cigar_op();
         r.op_length     = pick_length();
         if (k == 0) r.read_start = rstart;
         send_item(r, 1'b0, '0);
      end
      repeat ($urandom_range(0, 2)) begin
         r        = random_req();
         r.opcode = OPC_READOUT;
         if ($urandom_range(0, 1) == 0) r.query_index = 12'(rstart + $urandom_range(0, 150));
         send_item(r, 1'b0, '0);
      end
   endtask

   task automatic run_phase(input int n_items);
      int stop_at;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         gap_ceiling = ($urandom_range(0, 3) == 0) ? 0 : 14;
         if ($urandom_range(0, 9) == 0) send_item(random_req(), 1'b0, '0);
         else send_random_read();
         if ($urandom_range(0, 49) == 0) drain();
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_counts.size() == 0) begin
            report_mismatch("unexpected result (next_position)", rsp_data.next_position, '0);
         end else begin
            want = expected_counts.pop_front();
            if (rsp_data.coverage_count !== want.coverage_count)
               report_mismatch("coverage_count", rsp_data.coverage_count, want.coverage_count);
            if (rsp_data.mutation_count !== want.mutation_count)
               report_mismatch("mutation_count", rsp_data.mutation_count, want.mutation_count);
            if (rsp_data.read_count !== want.read_count)
               report_mismatch("read_count", rsp_data.read_count, want.read_count);
            if (rsp_data.next_position !== want.next_position)
               report_mismatch("next_position", rsp_data.next_position, want.next_position);
         end
      end
   end

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      gap_ceiling = 14;
      ref_settings[5] = 13'($urandom_range(2, 8191));

      // counts after reset, then a walk through the CIGAR codes, H apart, and one unused code
      directed.push_back('{make_readout(12'd0), 1, 1'b1, counts_of(0, 0, 0, 0)});
      directed.push_back('{make_readout(12'd4095), 1, 1'b1, counts_of(0, 0, 0, 0)});
      directed.push_back('{make_element(1'b1, 31'd10, OP_M, 28'd5, 1'b0), 1, 1'b1,
                           counts_of(0, 0, 0, 15)});
      directed.push_back('{make_element(1'b0, '0, OP_I, 28'd0, 1'b0), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b0, '0, OP_I, LEN_MAX, 1'b0), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b0, '0, OP_D, 28'd3, 1'b0), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b0, '0, OP_N, 28'd4, 1'b0), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b0, '0, OP_EQ, 28'd2, 1'b0), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b0, '0, OP_X, 28'd2, 1'b0), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b0, '0, OP_S, 28'd7, 1'b0), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b0, '0, OP_P, 28'd7, 1'b0), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b0, '0, OP_TOP, 28'd9, 1'b1), 1, 1'b0, '0});
      directed.push_back('{make_readout(12'd15), 1, 1'b0, '0});
      directed.push_back('{make_readout(12'd24), 1, 1'b0, '0});
      // empty read still counts, element without first mark reuses the position
      directed.push_back('{make_element(1'b1, '0, OP_M, 28'd0, 1'b1), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b0, START_MAX, OP_X, 28'd3, 1'b0), 1, 1'b0, '0});
      // readout ignores every element field and flag
      directed.push_back('{'{OPC_READOUT, 1'b1, START_MAX, OP_X, LEN_MAX, 1'b1, 12'd1}, 1,
                           1'b0, '0});
      // clipping at the end of the reference, then the whole store at once
      directed.push_back('{make_element(1'b1, 31'd4090, OP_M, LEN_MAX, 1'b1), 1, 1'b0, '0});
      directed.push_back('{make_readout(12'd4095), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b1, '0, OP_EQ, LEN_MAX, 1'b1), 1, 1'b0, '0});
      // drive the position into saturation
      directed.push_back('{make_element(1'b1, START_MAX, OP_N, LEN_MAX, 1'b0), 1, 1'b0, '0});
      directed.push_back('{make_element(1'b0, '0, OP_N, LEN_MAX, 1'b0), 8, 1'b0, '0});
      directed.push_back('{make_element(1'b0, '0, OP_I, 28'd1, 1'b1), 1, 1'b0, '0});
      directed.push_back('{make_readout(12'd20), 1, 1'b0, '0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         repeat (directed[i].reps) send_item(directed[i].item, directed[i].typed,
                                             directed[i].want);
      end
      drain();

      foreach (ref_settings[i]) begin
         set_ref_length(ref_settings[i]);
         run_phase(PHASE_ITEMS);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #(200_000_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
